FILE: src/fts_pkg.sv
// Shared types, constants and signature tables for the file type sniffer.
`timescale 1ns / 1ps

package fts_pkg;

    localparam int SigCount  = 16;
    localparam int SigMax    = 8;
    localparam int SigIdxW   = $clog2(SigMax);
    localparam int PosSat    = 9;
    localparam int PosWidth  = $clog2(PosSat + 1);
    localparam int MinLength = 3;

    typedef logic [3:0] class_t;
    typedef logic [PosWidth-1:0] pos_t;

    localparam class_t CLASS_UNKNOWN = 4'd0;
    localparam class_t CLASS_BMP     = 4'd1;
    localparam class_t CLASS_GIF     = 4'd2;
    localparam class_t CLASS_JPEG    = 4'd3;
    localparam class_t CLASS_MIDI    = 4'd4;
    localparam class_t CLASS_MP3     = 4'd5;
    localparam class_t CLASS_MP4     = 4'd6;
    localparam class_t CLASS_OGG     = 4'd7;
    localparam class_t CLASS_PDF     = 4'd8;
    localparam class_t CLASS_PNG     = 4'd9;
    localparam class_t CLASS_TEXT    = 4'd10;
    localparam class_t CLASS_TIFF    = 4'd11;

    // Allowed range of the continuation byte that follows a lead byte.
    localparam logic [2:0] RANGE_80_BF = 3'd0;
    localparam logic [2:0] RANGE_A0_BF = 3'd1;
    localparam logic [2:0] RANGE_80_9F = 3'd2;
    localparam logic [2:0] RANGE_90_BF = 3'd3;
    localparam logic [2:0] RANGE_80_8F = 3'd4;

    typedef struct packed {
        logic       text_valid;
        logic [1:0] cont_due;
        logic [2:0] cont_range;
    } utf8_state_t;

    localparam utf8_state_t UTF8_RESET = '{text_valid: 1'b1, cont_due: 2'd0,
                                           cont_range: RANGE_80_BF};

    localparam logic [7:0] SIG_BYTES [SigCount][SigMax] = '{
        '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h14, 8'h66, 8'h74, 8'h79, 8'h70},
        '{8'h00, 8'h00, 8'h00, 8'h20, 8'h66, 8'h74, 8'h79, 8'h70},
        '{8'h33, 8'h67, 8'h70, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h67, 8'h67, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
        '{8'hEF, 8'hBB, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam pos_t SIG_LEN [SigCount] = '{
        4'd2, 4'd6, 4'd6, 4'd3, 4'd4, 4'd3, 4'd2, 4'd8,
        4'd8, 4'd4, 4'd4, 4'd4, 4'd8, 4'd3, 4'd4, 4'd4
    };

    localparam class_t SIG_CLASS [SigCount] = '{
        CLASS_BMP, CLASS_GIF, CLASS_GIF, CLASS_JPEG,
        CLASS_MIDI, CLASS_MP3, CLASS_MP3, CLASS_MP4,
        CLASS_MP4, CLASS_MP4, CLASS_OGG, CLASS_PDF,
        CLASS_PNG, CLASS_TEXT, CLASS_TIFF, CLASS_TIFF
    };

endpackage

FILE: src/fts_sig.sv
// Magic signature comparison and first-match class selection.
`timescale 1ns / 1ps

module fts_sig (
    input  fts_pkg::pos_t                  pos,
    input  logic [7:0]                     data_byte,
    input  logic [fts_pkg::SigCount-1:0]   alive,
    output logic [fts_pkg::SigCount-1:0]   alive_next,
    output logic                           match_any,
    output fts_pkg::class_t                match_class
);

    always_comb
    begin
        alive_next = alive;
        for (int k = 0; k < fts_pkg::SigCount; k++)
        begin
            if ((pos < fts_pkg::SIG_LEN[k]) &&
                (data_byte != fts_pkg::SIG_BYTES[k][pos[fts_pkg::SigIdxW-1:0]]))
            begin
                alive_next[k] = 1'b0;
            end
        end
    end

    // Walk from the end of the table so the lowest surviving entry wins.
    always_comb
    begin
        match_class = fts_pkg::CLASS_UNKNOWN;
        for (int k = fts_pkg::SigCount - 1; k >= 0; k--)
        begin
            if (alive_next[k])
            begin
                match_class = fts_pkg::SIG_CLASS[k];
            end
        end
    end

    assign match_any = |alive_next;

endmodule

FILE: src/fts_utf8.sv
// One-byte step of the UTF-8 text validator.
`timescale 1ns / 1ps

module fts_utf8 (
    input  logic [7:0]           data_byte,
    input  fts_pkg::utf8_state_t state_cur,
    output fts_pkg::utf8_state_t state_next
);

    logic cont_ok;

    always_comb
    begin
        unique case (state_cur.cont_range)
            fts_pkg::RANGE_A0_BF: cont_ok = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
            fts_pkg::RANGE_80_9F: cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'h9F);
            fts_pkg::RANGE_90_BF: cont_ok = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
            fts_pkg::RANGE_80_8F: cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'h8F);
            default:              cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
        endcase
    end

    always_comb
    begin
        state_next = state_cur;
        if (state_cur.text_valid)
        begin
            if (state_cur.cont_due != 2'd0)
            begin
                if (!cont_ok)
                begin
                    state_next.text_valid = 1'b0;
                end
                state_next.cont_range = fts_pkg::RANGE_80_BF;
                state_next.cont_due   = state_cur.cont_due - 2'd1;
            end
            else
            begin
                priority if (data_byte < 8'h20)
                begin
                    // Only tab, line feed, vertical tab and carriage return pass.
                    if (!((data_byte == 8'h09) || (data_byte == 8'h0A) ||
                          (data_byte == 8'h0B) || (data_byte == 8'h0D)))
                    begin
                        state_next.text_valid = 1'b0;
                    end
                end
                else if (data_byte <= 8'h7F)
                begin
                    state_next.text_valid = 1'b1;
                end
                else if (data_byte < 8'hC2)
                begin
                    state_next.text_valid = 1'b0;
                end
                else if (data_byte <= 8'hDF)
                begin
                    state_next.cont_due   = 2'd1;
                    state_next.cont_range = fts_pkg::RANGE_80_BF;
                end
                else if (data_byte <= 8'hEF)
                begin
                    state_next.cont_due = 2'd2;
                    if (data_byte == 8'hE0)
                    begin
                        state_next.cont_range = fts_pkg::RANGE_A0_BF;
                    end
                    else if (data_byte == 8'hED)
                    begin
                        state_next.cont_range = fts_pkg::RANGE_80_9F;
                    end
                    else
                    begin
                        state_next.cont_range = fts_pkg::RANGE_80_BF;
                    end
                end
                else if (data_byte <= 8'hF4)
                begin
                    state_next.cont_due = 2'd3;
                    if (data_byte == 8'hF0)
                    begin
                        state_next.cont_range = fts_pkg::RANGE_90_BF;
                    end
                    else if (data_byte == 8'hF4)
                    begin
                        state_next.cont_range = fts_pkg::RANGE_80_8F;
                    end
                    else
                    begin
                        state_next.cont_range = fts_pkg::RANGE_80_BF;
                    end
                end
                else
                begin
                    state_next.text_valid = 1'b0;
                end
            end
        end
    end

endmodule

FILE: src/file_type_sniffer_unit.sv
// Usage notes:
// The input channel (in_valid, in_stall, data_byte, is_last) carries one byte of a
// buffer per transaction; is_last marks the final byte. The output channel
// (out_valid, out_stall, file_class) carries one class code per buffer, sent
// after its last byte. Bytes are taken one per cycle while in_stall is low, with
// no gaps needed between buffers. A byte is held in the input register, then
// updates the signature and UTF-8 state; a last byte loads the result register,
// which drives file_class. Throughput is one byte per cycle while in_stall is
// low, set by the single update stage.
// While a result waits under out_stall, bytes that are not last keep flowing;
// only a second last byte is held in the input register, and in_stall rises
// once that register cannot move on.
// Reset clears the position, the signature flags (all alive), the UTF-8 state
// and both valid flags; the state also returns to reset after every result.
`timescale 1ns / 1ps

module file_type_sniffer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                is_last,
    output logic                out_valid,
    input  logic                out_stall,
    output fts_pkg::class_t     file_class
);

    logic                         s1_valid_reg;
    logic [7:0]                   s1_byte_reg;
    logic                         s1_last_reg;
    logic                         s1_advance;
    logic                         in_accept;

    fts_pkg::pos_t                pos_reg;
    fts_pkg::pos_t                pos_next;
    logic [fts_pkg::SigCount-1:0] alive_reg;
    logic [fts_pkg::SigCount-1:0] alive_next;
    fts_pkg::utf8_state_t         utf_reg;
    fts_pkg::utf8_state_t         utf_next;

    logic                         match_any;
    fts_pkg::class_t              match_class;
    fts_pkg::class_t              class_next;

    logic                         out_valid_reg;
    fts_pkg::class_t              file_class_reg;

    // A last byte may only move on when the result register is free or draining.
    assign s1_advance = s1_valid_reg && !(s1_last_reg && out_valid_reg && out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    fts_sig u_sig (
        .pos         (pos_reg),
        .data_byte   (s1_byte_reg),
        .alive       (alive_reg),
        .alive_next  (alive_next),
        .match_any   (match_any),
        .match_class (match_class)
    );

    fts_utf8 u_utf8 (
        .data_byte  (s1_byte_reg),
        .state_cur  (utf_reg),
        .state_next (utf_next)
    );

    assign pos_next = (pos_reg < fts_pkg::pos_t'(fts_pkg::PosSat)) ?
                      pos_reg + fts_pkg::pos_t'(1) : pos_reg;

    // The buffer is long enough when this byte brings the count above three.
    always_comb
    begin
        class_next = fts_pkg::CLASS_UNKNOWN;
        if (pos_reg >= fts_pkg::pos_t'(fts_pkg::MinLength))
        begin
            if (match_any)
            begin
                class_next = match_class;
            end
            else if (utf_next.text_valid)
            begin
                class_next = fts_pkg::CLASS_TEXT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            alive_reg <= '1;
            utf_reg   <= fts_pkg::UTF8_RESET;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                pos_reg   <= '0;
                alive_reg <= '1;
                utf_reg   <= fts_pkg::UTF8_RESET;
            end
            else
            begin
                pos_reg   <= pos_next;
                alive_reg <= alive_next;
                utf_reg   <= utf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            file_class_reg <= class_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign file_class = file_class_reg;

endmodule

FILE: dv/tb_top.sv
// Testbench for file_type_sniffer_unit: byte buffers checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int ByteTarget = 1150;
    localparam int QuietFrom  = 1000;
    localparam int DirCount   = 8;

    // Directed buffers laid end to end, with the length of each.
    localparam logic [7:0] DIR_BYTES [28] = '{
        8'h7F,
        8'h42, 8'h4D, 8'h00,
        8'h42, 8'h4D, 8'h00, 8'hFF,
        8'hFF, 8'hFB, 8'h90, 8'h00,
        8'h61, 8'h62, 8'hE0, 8'hA0,
        8'h09, 8'h0A, 8'h0B, 8'h0D,
        8'h61, 8'h62, 8'h63, 8'h80,
        8'h00, 8'h61, 8'h62, 8'h63
    };
    localparam int DIR_LENS [DirCount] = '{1, 3, 4, 4, 4, 4, 4, 4};

    localparam logic [7:0] TEXT_CONTROLS [4] = '{8'h09, 8'h0A, 8'h0B, 8'h0D};
    localparam logic [7:0] EDGE_BYTES [21] = '{
        8'h00, 8'h01, 8'h1F, 8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0, 8'hBF, 8'hC0,
        8'hC1, 8'hC2, 8'hDF, 8'hE0, 8'hED, 8'hEF, 8'hF0, 8'hF4, 8'hF5, 8'hFF
    };

    class class_tracker;
        fts_pkg::pos_t                seen_count;
        logic [fts_pkg::SigCount-1:0] sig_alive;
        fts_pkg::utf8_state_t         utf8;
        fts_pkg::class_t              pending_classes[$];
        int                           mismatches;

        function new();
            clear_buffer();
            mismatches = 0;
        endfunction

        function void clear_buffer();
            seen_count = '0;
            sig_alive  = '1;
            utf8       = fts_pkg::UTF8_RESET;
        endfunction

        function bit cont_in_range(logic [7:0] octet, logic [2:0] rng);
            case (rng)
                fts_pkg::RANGE_A0_BF: return octet >= 8'hA0 && octet <= 8'hBF;
                fts_pkg::RANGE_80_9F: return octet >= 8'h80 && octet <= 8'h9F;
                fts_pkg::RANGE_90_BF: return octet >= 8'h90 && octet <= 8'hBF;
                fts_pkg::RANGE_80_8F: return octet >= 8'h80 && octet <= 8'h8F;
                default:              return octet >= 8'h80 && octet <= 8'hBF;
            endcase
        endfunction

        function void step_utf8(logic [7:0] octet);
            if (!utf8.text_valid)
                return;
            if (utf8.cont_due != 2'd0)
            begin
                if (!cont_in_range(octet, utf8.cont_range))
                    utf8.text_valid = 1'b0;
                utf8.cont_range = fts_pkg::RANGE_80_BF;
                utf8.cont_due   = utf8.cont_due - 2'd1;
            end
            else if (octet < 8'h20)
            begin
                if (!(octet == 8'h09 || octet == 8'h0A || octet == 8'h0B || octet == 8'h0D))
                    utf8.text_valid = 1'b0;
            end
            else if (octet >= 8'h80)
            begin
                if (octet < 8'hC2 || octet >= 8'hF5)
                    utf8.text_valid = 1'b0;
                else if (octet <= 8'hDF)
                begin
                    utf8.cont_due   = 2'd1;
                    utf8.cont_range = fts_pkg::RANGE_80_BF;
                end
                else if (octet <= 8'hEF)
                begin
                    utf8.cont_due   = 2'd2;
                    utf8.cont_range = (octet == 8'hE0) ? fts_pkg::RANGE_A0_BF :
                                      (octet == 8'hED) ? fts_pkg::RANGE_80_9F :
                                      fts_pkg::RANGE_80_BF;
                end
                else
                begin
                    utf8.cont_due   = 2'd3;
                    utf8.cont_range = (octet == 8'hF0) ? fts_pkg::RANGE_90_BF :
                                      (octet == 8'hF4) ? fts_pkg::RANGE_80_8F :
                                      fts_pkg::RANGE_80_BF;
                end
            end
        endfunction

        // Notes one accepted byte; a last byte yields the expected class.
        function void take_byte(logic [7:0] octet, logic last);
            fts_pkg::class_t verdict;
            int              k;
            verdict = fts_pkg::CLASS_UNKNOWN;
            for (k = 0; k < fts_pkg::SigCount; k++)
            begin
                if (seen_count < fts_pkg::SIG_LEN[k] &&
                    octet != fts_pkg::SIG_BYTES[k][seen_count[2:0]])
                    sig_alive[k] = 1'b0;
            end
            step_utf8(octet);
            if (seen_count < fts_pkg::PosSat)
                seen_count = seen_count + 1'b1;
            if (last)
            begin
                if (seen_count > fts_pkg::MinLength)
                begin
                    // Walk downward so the lowest surviving signature wins.
                    for (k = fts_pkg::SigCount - 1; k >= 0; k--)
                    begin
                        if (sig_alive[k])
                            verdict = fts_pkg::SIG_CLASS[k];
                    end
                    if (sig_alive == '0 && utf8.text_valid)
                        verdict = fts_pkg::CLASS_TEXT;
                end
                pending_classes.push_back(verdict);
                clear_buffer();
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_class(fts_pkg::class_t got);
            fts_pkg::class_t want;
            if (pending_classes.size() == 0)
                report_mismatch($sformatf("file_class %0d with none expected", got));
            else
            begin
                want = pending_classes.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("file_class %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [7:0]      data_byte;
    logic            is_last;
    logic            out_valid;
    logic            out_stall = 1'b0;
    fts_pkg::class_t file_class;

    class_tracker tracker = new();
    logic [7:0]   chunk_q[$];
    int           sent_count;
    int           stall_left;
    bit           quiet_tail;

    file_type_sniffer_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .file_class (file_class)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** file_type_sniffer_unit: FAILED **");
        $finish;
    end

    // Result side: check each transaction and stall in random bursts.
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && !out_stall)
            tracker.check_class(file_class);
        if (quiet_tail)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_chunk();
        int  gap;
        logic final_byte;
        foreach (chunk_q[i])
        begin
            final_byte = (i == chunk_q.size() - 1);
            if (!quiet_tail && $urandom_range(0, 11) == 0)
            begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= chunk_q[i];
            is_last   <= final_byte;
            do
                @(posedge clk);
            while (in_stall);
            tracker.take_byte(chunk_q[i], final_byte);
            sent_count++;
            if (sent_count >= QuietFrom)
                quiet_tail = 1'b1;
        end
        chunk_q.delete();
    endtask

    function automatic void add_utf8_char();
        logic [7:0] lead;
        case ($urandom_range(0, 9))
            0, 1, 2: chunk_q.push_back(8'($urandom_range(8'h20, 8'h7F)));
            3: chunk_q.push_back(TEXT_CONTROLS[$urandom_range(0, 3)]);
            4:
            begin
                chunk_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                chunk_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            5:
            begin
                chunk_q.push_back(8'hE0);
                chunk_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                chunk_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            6:
            begin
                lead = 8'($urandom_range(8'hE1, 8'hEF));
                chunk_q.push_back(lead);
                chunk_q.push_back(8'($urandom_range(8'h80, (lead == 8'hED) ? 8'h9F : 8'hBF)));
                chunk_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            7:
            begin
                chunk_q.push_back(8'hF0);
                chunk_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
                chunk_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                chunk_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default:
            begin
                lead = 8'($urandom_range(8'hF1, 8'hF4));
                chunk_q.push_back(lead);
                chunk_q.push_back(8'($urandom_range(8'h80, (lead == 8'hF4) ? 8'h8F : 8'hBF)));
                chunk_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                chunk_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endfunction

    // Maybe overwrites one byte with a boundary value or noise, then maybe cuts the tail.
    function automatic void damage_chunk(int corrupt_odds, int trim_odds);
        int target;
        if ($urandom_range(1, corrupt_odds) == 1)
            chunk_q[$urandom_range(0, chunk_q.size() - 1)] = $urandom_range(0, 1) ?
                EDGE_BYTES[$urandom_range(0, 20)] : 8'($urandom_range(0, 255));
        if ($urandom_range(1, trim_odds) == 1)
        begin
            target = $urandom_range(1, chunk_q.size());
            while (chunk_q.size() > target)
                void'(chunk_q.pop_back());
        end
    endfunction

    initial
    begin
        int pick;
        int n;
        int base;
        in_valid   <= 1'b0;
        data_byte  <= 8'h00;
        is_last    <= 1'b0;
        rst_n      <= 1'b0;
        sent_count = 0;
        stall_left = 0;
        quiet_tail = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        base = 0;
        for (int d = 0; d < DirCount; d++)
        begin
            for (int j = 0; j < DIR_LENS[d]; j++)
                chunk_q.push_back(DIR_BYTES[base + j]);
            base += DIR_LENS[d];
            send_chunk();
        end

        while (sent_count < ByteTarget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                // Signature prefix followed by text or noise.
                n = $urandom_range(0, fts_pkg::SigCount - 1);
                for (int j = 0; j < fts_pkg::SIG_LEN[n]; j++)
                    chunk_q.push_back(fts_pkg::SIG_BYTES[n][j]);
                repeat ($urandom_range(0, 6))
                begin
                    if ($urandom_range(0, 1))
                        add_utf8_char();
                    else
                        chunk_q.push_back(8'($urandom_range(0, 255)));
                end
                damage_chunk(5, 5);
            end
            else if (pick < 8)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 10);
                repeat (n) add_utf8_char();
                damage_chunk(3, 4);
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    chunk_q.push_back(8'($urandom_range(0, 255)));
            end
            send_chunk();
        end
        in_valid <= 1'b0;

        while (tracker.pending_classes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("** file_type_sniffer_unit: PASSED **");
        else
            $display("** file_type_sniffer_unit: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
src/fts_pkg.sv
src/fts_sig.sv
src/fts_utf8.sv
src/file_type_sniffer_unit.sv
dv/tb_top.sv
